// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block, bsa_checker.sv.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/bsa_pkg.sv =====
// Package of the bit slot allocator: sizes, operation, status and state codes,
// transfer payload structs and the controller/datapath command and status structs.
package bsa_pkg;

    localparam int MAX_BYTES   = 255;
    localparam int START_BYTES = 4;
    // Start size clamped to the legal range.
    localparam int START_EFF   = (START_BYTES > MAX_BYTES) ? MAX_BYTES :
                                 ((START_BYTES < 1) ? 1 : START_BYTES);

    localparam logic [7:0] MAX_SIZE   = 8'(MAX_BYTES);
    localparam logic [7:0] START_SIZE = 8'(START_EFF);
    localparam logic [7:0] CLR_LAST   = 8'(START_EFF - 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [7:0] byte_index;
        logic [7:0] bit_mask;
        logic       set_value;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] slot_byte;
        logic [7:0] slot_mask;
        logic       value_out;
        logic [7:0] bytes_in_use;
    } t_out_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic scan_inc;
        logic alloc_hit;
        logic alloc_grow;
        logic alloc_full;
        logic access;
        logic range_err;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_alloc;
        logic idx_live;
        logic byte_full;
        logic scan_last;
        logic at_max;
        logic clear_last;
    } t_dp_sts;

endpackage

// ===== rtl/core/bsa_dp.sv =====
// Datapath of the bit slot allocator: used and value byte memories, size and
// scan registers, and the result register. Depends on bsa_pkg.
module bsa_dp import bsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_item o_out_item
);

    logic [7:0] mem_used  [0:MAX_BYTES-1];
    logic [7:0] mem_value [0:MAX_BYTES-1];

    logic [7:0] r_used_rd, r_value_rd;
    t_op        r_op;
    logic [7:0] r_idx, r_mask;
    logic       r_setv;
    logic [7:0] r_size, n_size;
    logic [7:0] r_scan, n_scan;
    t_out_item  r_res, n_res;

    logic [7:0] rd_addr, wr_addr;
    logic       used_we, value_we;
    logic [7:0] used_wd, value_wd;
    logic [7:0] low_zero;
    logic       finish;

    // Lowest clear bit of the byte just read, as a one-hot mask.
    assign low_zero = ~r_used_rd & (r_used_rd + 8'd1);
    assign finish   = i_cmd.alloc_hit | i_cmd.alloc_grow | i_cmd.alloc_full |
                      i_cmd.access | i_cmd.range_err;

    // The scan address runs one ahead when the scan advances, so each cycle
    // of the check state sees the byte at the current scan position.
    always_comb begin
        if (r_op == OP_ALLOC) begin
            rd_addr = i_cmd.scan_inc ? r_scan + 8'd1 : r_scan;
        end else begin
            rd_addr = r_idx;
        end
    end

    always_comb begin
        wr_addr  = r_idx;
        used_we  = 1'b0;
        value_we = 1'b0;
        used_wd  = 8'd0;
        value_wd = 8'd0;
        if (i_cmd.clear_wr) begin
            wr_addr  = r_scan;
            used_we  = 1'b1;
            value_we = 1'b1;
        end else if (i_cmd.alloc_hit) begin
            wr_addr = r_scan;
            used_we = 1'b1;
            used_wd = r_used_rd | low_zero;
        end else if (i_cmd.alloc_grow) begin
            wr_addr  = r_size;
            used_we  = 1'b1;
            value_we = 1'b1;
            used_wd  = 8'd1;
        end else if (i_cmd.access) begin
            used_we  = (r_op == OP_FREE);
            value_we = (r_op == OP_WRITE);
            used_wd  = r_used_rd & ~r_mask;
            value_wd = r_setv ? (r_value_rd | r_mask) : (r_value_rd & ~r_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (used_we) begin
            mem_used[wr_addr] <= used_wd;
        end
        if (value_we) begin
            mem_value[wr_addr] <= value_wd;
        end
        if (rd_addr < MAX_SIZE) begin
            r_used_rd  <= mem_used[rd_addr];
            r_value_rd <= mem_value[rd_addr];
        end
    end

    always_comb begin
        n_scan = r_scan;
        if (i_cmd.load_in) begin
            n_scan = 8'd0;
        end else if (i_cmd.clear_wr || i_cmd.scan_inc) begin
            n_scan = r_scan + 8'd1;
        end
        n_size = i_cmd.alloc_grow ? r_size + 8'd1 : r_size;
    end

    always_comb begin
        n_res = r_res;
        if (finish) begin
            n_res.status       = i_cmd.range_err  ? ST_RANGE :
                                 i_cmd.alloc_full ? ST_FULL  : ST_OK;
            n_res.slot_byte    = i_cmd.alloc_hit  ? r_scan :
                                 i_cmd.alloc_grow ? r_size : 8'd0;
            n_res.slot_mask    = i_cmd.alloc_hit  ? low_zero :
                                 i_cmd.alloc_grow ? 8'd1 : 8'd0;
            n_res.value_out    = i_cmd.access && (r_op == OP_READ) &&
                                 ((r_value_rd & r_mask) != 8'd0);
            n_res.bytes_in_use = n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= START_SIZE;
            r_scan <= 8'd0;
        end else begin
            r_size <= n_size;
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.load_in) begin
            r_op   <= i_in_item.operation;
            r_idx  <= i_in_item.byte_index;
            r_mask <= i_in_item.bit_mask;
            r_setv <= i_in_item.set_value;
        end
    end

    assign o_sts.is_alloc   = (r_op == OP_ALLOC);
    assign o_sts.idx_live   = (r_idx < r_size);
    assign o_sts.byte_full  = (r_used_rd == 8'hFF);
    assign o_sts.scan_last  = (r_scan == r_size - 8'd1);
    assign o_sts.at_max     = (r_size == MAX_SIZE);
    assign o_sts.clear_last = (r_scan == CLR_LAST);
    assign o_out_item       = r_res;

endmodule

// ===== rtl/core/bsa_ctrl.sv =====
// Controller of the bit slot allocator: state machine that sequences the
// clearing pass, operand load and byte scan, and owns the result valid flag.
module bsa_ctrl import bsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   finish;

    // The result register can take a new result when empty or when drained now.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.byte_full && !i_sts.scan_last) begin
                        o_cmd.scan_inc = 1'b1;
                    end else if (out_free) begin
                        n_state = S_IDLE;
                        if (!i_sts.byte_full) begin
                            o_cmd.alloc_hit = 1'b1;
                        end else if (i_sts.at_max) begin
                            o_cmd.alloc_full = 1'b1;
                        end else begin
                            o_cmd.alloc_grow = 1'b1;
                        end
                    end
                end else if (out_free) begin
                    n_state = S_IDLE;
                    if (i_sts.idx_live) begin
                        o_cmd.access = 1'b1;
                    end else begin
                        o_cmd.range_err = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign finish = o_cmd.alloc_hit | o_cmd.alloc_grow | o_cmd.alloc_full |
                    o_cmd.access | o_cmd.range_err;

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/bit_slot_allocator.sv =====
// Bit slot allocator: a byte-organized slot bitmap with one flag bit per slot.
// Input transfer: i_in_valid / o_in_stall with payload i_in_item (operation,
// byte_index, bit_mask, set_value). Output transfer: o_out_valid / i_out_stall
// with payload o_out_item (status, slot_byte, slot_mask, value_out,
// bytes_in_use). Exactly one result follows each accepted item, in order.
// After reset the block stalls its input while it clears the START_EFF bytes
// (4 by default) that start out live; later bytes are written when the maps
// grow, before they are ever read. Free, write and read pass through the read
// and check states, and the result is registered when the check state ends.
// Allocate scans the used map one byte per cycle through the memory read
// port: a slot found in byte k is ready once the check state reaches byte k,
// and a full or growing map once it reaches the last live byte.
// One item is in work at a time; the next is accepted in the cycle after
// the result is written, even while that result is still stalled.
// If the receiver stalls, the result is held and a finishing item waits.
module bit_slot_allocator import bsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bsa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

// ===== rtl/core/bsa_checker.sv =====
// Port-level checker of the bit slot allocator and its bind to the top level.
// Depends on bsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsa_checker import bsa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input t_in_item  i_in_item,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    logic out_held, in_xfer;
    logic full_seen, full_clean;
    logic slot_seen, slot_clean;
    logic read_hit, read_ok;

    assign out_held   = i_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !i_in_stall;
    assign full_seen  = i_out_valid && (i_out_item.status == ST_FULL);
    assign full_clean = (i_out_item.slot_mask == 8'd0) && (i_out_item.slot_byte == 8'd0) &&
                        (i_out_item.bytes_in_use == MAX_SIZE);
    assign slot_seen  = i_out_valid && (i_out_item.slot_mask != 8'd0);
    assign slot_clean = $onehot(i_out_item.slot_mask) && (i_out_item.status == ST_OK) &&
                        (i_out_item.slot_byte < i_out_item.bytes_in_use);
    assign read_hit   = i_out_valid && i_out_item.value_out;
    assign read_ok    = (i_out_item.status == ST_OK);

    // A stalled result stays valid and unchanged.
    `BSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, i_out_valid && $stable(i_out_item))

    // Only one item is in work, so the input stalls right after a transfer.
    `BSA_ASSERT_NXT(a_one_in_work, i_clk, i_rst_n, in_xfer, i_in_stall)

    // A full report hands out no slot and comes only at the maximum size.
    `BSA_ASSERT_IMP(a_full_report, i_clk, i_rst_n, full_seen, full_clean)

    // A handed-out slot is one bit inside the live bytes.
    `BSA_ASSERT_IMP(a_slot_legal, i_clk, i_rst_n, slot_seen, slot_clean)

    // A read result is never reported together with an error.
    `BSA_ASSERT_IMP(a_value_ok, i_clk, i_rst_n, read_hit, read_ok)

endmodule

bind bit_slot_allocator bsa_checker u_bsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
